FILE: src/jic_pkg.sv
// ----------------------------------------------------------------------------
// jic_pkg
// Shared types and codes of the instanceof type-check unit.
// ----------------------------------------------------------------------------
package jic_pkg;

  localparam int unsigned IdW    = 8;
  localparam int unsigned KindW  = 4;
  localparam int unsigned CountW = 9;
  localparam int unsigned ErrW   = 3;

  localparam logic [1:0] OP_WR_CLASS = 2'd0;
  localparam logic [1:0] OP_WR_SLOT  = 2'd1;
  localparam logic [1:0] OP_QUERY    = 2'd2;

  localparam logic [KindW-1:0] KIND_CLASS = 4'd0;
  localparam logic [KindW-1:0] KIND_IFACE = 4'd1;
  localparam logic [KindW-1:0] KIND_OARR  = 4'd2;
  localparam logic [KindW-1:0] KIND_PLO   = 4'd3;
  localparam logic [KindW-1:0] KIND_PHI   = 4'd10;

  localparam logic [ErrW-1:0] ERR_OK     = 3'd0;
  localparam logic [ErrW-1:0] ERR_RANGE  = 3'd1;
  localparam logic [ErrW-1:0] ERR_STYPE  = 3'd2;
  localparam logic [ErrW-1:0] ERR_AIFACE = 3'd3;
  localparam logic [ErrW-1:0] ERR_WALK   = 3'd4;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [IdW-1:0]    write_index;
    logic [KindW-1:0]  entry_kind;
    logic [IdW-1:0]    entry_super;
    logic [IdW-1:0]    entry_element;
    logic [IdW-1:0]    entry_list_start;
    logic [CountW-1:0] entry_list_count;
    logic [IdW-1:0]    slot_value;
    logic [IdW-1:0]    query_s;
    logic [IdW-1:0]    query_t;
  } item_t;

  typedef struct packed {
    logic            is_instance;
    logic [ErrW-1:0] error_code;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture item, write tables
    logic rd_st;      // read class entries of s and t
    logic dec;        // decode kinds, may descend
    logic walk_rd;    // read entry of cur
    logic walk_chk;   // compare super
    logic lst_init;   // set slot index and count
    logic lst_rd;     // read slot
    logic lst_chk;    // compare slot
  } cmd_t;

  typedef enum logic [2:0] {
    DEC_DONE, DEC_DESCEND, DEC_WALK, DEC_LIST
  } dec_t;

  // datapath -> controller
  typedef struct packed {
    logic is_query;
    dec_t dec;
    logic walk_done;
    logic lst_done;
  } stat_t;

  function automatic logic is_prim(logic [KindW-1:0] k);
    return (k >= KIND_PLO) && (k <= KIND_PHI);
  endfunction

endpackage

FILE: src/jic_stream_if.sv
// ----------------------------------------------------------------------------
// jic_stream_if
// Valid/ready channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface jic_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/jic_datapath.sv
// ----------------------------------------------------------------------------
// jic_datapath
// Class tables, interface list and the compare logic of one query.
// ----------------------------------------------------------------------------
module jic_datapath
  import jic_pkg::*;
#(
  parameter int unsigned MAX_CLASSES    = 256,
  parameter int unsigned MAX_LIST_SLOTS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  item_t             item,
  input  logic [CountW-1:0] class_count,
  input  cmd_t              cmd,
  output stat_t             stat,
  output result_t           res
);

  localparam int unsigned CA = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int unsigned LA = (MAX_LIST_SLOTS > 1) ? $clog2(MAX_LIST_SLOTS) : 1;
  localparam int unsigned NW = $clog2(MAX_CLASSES + 1) + 1;
  localparam int unsigned IW = IdW + 2;

  logic [KindW-1:0]  kind_mem  [MAX_CLASSES];
  logic [IdW-1:0]    super_mem [MAX_CLASSES];
  logic [IdW-1:0]    elem_mem  [MAX_CLASSES];
  logic [IdW-1:0]    start_mem [MAX_CLASSES];
  logic [CountW-1:0] count_mem [MAX_CLASSES];
  logic [IdW-1:0]    list_mem  [MAX_LIST_SLOTS];

  logic              is_query_r;
  logic [IdW-1:0]    s_r, t_r, cur_r;
  logic [NW-1:0]     steps_r;
  logic [KindW-1:0]  ks_r, kt_r;
  logic [IdW-1:0]    es_r, et_r, sup_r, st_r, slot_r;
  logic [CountW-1:0] cnt_r, left_r;
  logic [IW-1:0]     idx_r;
  logic              hit_r;
  logic [ErrW-1:0]   err_r;

  function automatic logic id_ok(logic [IdW-1:0] id, logic [CountW-1:0] cc);
    return ({1'b0, id} < cc) && (32'(id) < MAX_CLASSES);
  endfunction

  logic [CA-1:0] s_a, t_a, c_a;
  assign s_a = CA'(s_r);
  assign t_a = CA'(t_r);
  assign c_a = CA'(cur_r);

  always_ff @(posedge clk) begin
    if (cmd.load && item.opcode == OP_WR_CLASS && 32'(item.write_index) < MAX_CLASSES) begin
      kind_mem[CA'(item.write_index)]  <= item.entry_kind;
      super_mem[CA'(item.write_index)] <= item.entry_super;
      elem_mem[CA'(item.write_index)]  <= item.entry_element;
      start_mem[CA'(item.write_index)] <= item.entry_list_start;
      count_mem[CA'(item.write_index)] <= item.entry_list_count;
    end
    if (cmd.load && item.opcode == OP_WR_SLOT && 32'(item.write_index) < MAX_LIST_SLOTS) begin
      list_mem[LA'(item.write_index)] <= item.slot_value;
    end
    if (cmd.rd_st) begin
      ks_r  <= kind_mem[s_a];
      kt_r  <= kind_mem[t_a];
      es_r  <= elem_mem[s_a];
      et_r  <= elem_mem[t_a];
      st_r  <= start_mem[s_a];
      cnt_r <= count_mem[s_a];
    end
    if (cmd.walk_rd) sup_r <= super_mem[c_a];
    if (cmd.lst_rd) slot_r <= list_mem[LA'(idx_r)];
  end

  dec_t dec;
  logic [ErrW-1:0] dec_err;
  logic dec_hit;
  logic ids_ok;
  assign ids_ok = id_ok(t_r, class_count) && id_ok(s_r, class_count);

  always_comb begin
    dec = DEC_DONE;
    dec_err = ERR_OK;
    dec_hit = 1'b0;
    if (!ids_ok) begin
      dec_err = ERR_RANGE;
    end else if (ks_r == KIND_OARR || is_prim(ks_r)) begin
      if (kt_r == KIND_OARR) begin
        if (ks_r == KIND_OARR) begin
          if (32'(steps_r) + 1 >= MAX_CLASSES) dec_err = ERR_WALK;
          else dec = DEC_DESCEND;
        end
      end else if (is_prim(kt_r)) begin
        dec_hit = (s_r == t_r);
      end else if (kt_r == KIND_CLASS) begin
        dec_hit = (t_r == '0);
      end else begin
        dec_err = ERR_AIFACE;
      end
    end else if (ks_r == KIND_CLASS) begin
      if (kt_r == KIND_CLASS) begin
        if (s_r == t_r) dec_hit = 1'b1;
        else dec = DEC_WALK;
      end else if (kt_r == KIND_IFACE) begin
        dec = DEC_LIST;
      end
    end else begin
      dec_err = ERR_STYPE;
    end
  end

  logic walk_end_now;
  assign walk_end_now = (cur_r == '0) || !id_ok(cur_r, class_count) ||
                        (32'(steps_r) >= MAX_CLASSES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_query_r <= 1'b0;
      hit_r <= 1'b0;
      err_r <= ERR_OK;
    end else begin
      if (cmd.load) begin
        is_query_r <= (item.opcode == OP_QUERY);
        s_r <= item.query_s;
        t_r <= item.query_t;
        hit_r <= 1'b0;
        err_r <= ERR_OK;
        steps_r <= '0;
      end
      if (cmd.dec) begin
        hit_r <= dec_hit;
        err_r <= dec_err;
        cur_r <= s_r;
        if (dec == DEC_DESCEND) begin
          s_r <= es_r;
          t_r <= et_r;
          steps_r <= steps_r + 1'b1;
        end else begin
          steps_r <= '0;
        end
      end
      if (cmd.walk_rd) begin
        if (cur_r != '0 && 32'(steps_r) < MAX_CLASSES && !id_ok(cur_r, class_count))
          err_r <= ERR_RANGE;
        else if (cur_r != '0 && 32'(steps_r) >= MAX_CLASSES)
          err_r <= ERR_WALK;
      end
      if (cmd.walk_chk) begin
        if (sup_r == t_r) hit_r <= 1'b1;
        cur_r <= sup_r;
        steps_r <= steps_r + 1'b1;
      end
      if (cmd.lst_init) begin
        idx_r <= IW'(st_r);
        left_r <= cnt_r;
      end
      if (cmd.lst_chk) begin
        if (32'(idx_r) < MAX_LIST_SLOTS && slot_r == t_r) hit_r <= 1'b1;
        idx_r <= idx_r + 1'b1;
        left_r <= left_r - 1'b1;
      end
    end
  end

  assign stat.is_query  = is_query_r;
  assign stat.dec       = dec;
  assign stat.walk_done = walk_end_now || hit_r;
  assign stat.lst_done  = (left_r == '0) || hit_r;

  assign res.error_code  = err_r;
  assign res.is_instance = hit_r && (err_r == ERR_OK);

endmodule

FILE: src/jic_ctrl.sv
// ----------------------------------------------------------------------------
// jic_ctrl
// Sequencer of one item: table write, kind decode, super walk, list scan.
// ----------------------------------------------------------------------------
module jic_ctrl
  import jic_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_fire,
  input  logic  out_fire,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy,
  output logic  done
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_DEC, S_WRD, S_WCHK, S_LINIT, S_LRD, S_LCHK, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (!stat.is_query) state_nxt = S_OUT;
        else begin
          cmd.rd_st = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.dec = 1'b1;
        case (stat.dec)
          DEC_DESCEND: state_nxt = S_RD;
          DEC_WALK:    state_nxt = S_WRD;
          DEC_LIST:    state_nxt = S_LINIT;
          default:     state_nxt = S_OUT;
        endcase
      end
      S_WRD: begin
        cmd.walk_rd = 1'b1;
        state_nxt = stat.walk_done ? S_OUT : S_WCHK;
      end
      S_WCHK: begin
        cmd.walk_chk = 1'b1;
        state_nxt = S_WRD;
      end
      S_LINIT: begin
        cmd.lst_init = 1'b1;
        state_nxt = S_LRD;
      end
      S_LRD: begin
        if (stat.lst_done) state_nxt = S_OUT;
        else begin
          cmd.lst_rd = 1'b1;
          state_nxt = S_LCHK;
        end
      end
      S_LCHK: begin
        cmd.lst_chk = 1'b1;
        state_nxt = S_LRD;
      end
      S_OUT: begin
        if (out_fire) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_OUT);

endmodule

FILE: src/jvm_instanceof_checker.sv
// ----------------------------------------------------------------------------
// jvm_instanceof_checker
// A write gives its result beat with no table read; a query reads and decodes
// the entries of s and t, again per array level, then walks the superclass
// chain or scans the interface-list slots, one read and one compare per step.
// Throughput: one item at a time; a new beat is taken at the earliest in the
// cycle after the result beat leaves. Set by the sequential table walk.
// Reset: synchronous; class_count returns to 1, tables hold until written.
// ----------------------------------------------------------------------------
module jvm_instanceof_checker
  import jic_pkg::*;
#(
  parameter int unsigned MAX_CLASSES    = 256,
  parameter int unsigned MAX_LIST_SLOTS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  jic_stream_if.sink        in_ch,
  jic_stream_if.source      out_ch,
  input  logic              cfg_we,
  input  logic [CountW-1:0] cfg_wdata
);

  logic [CountW-1:0] class_count_r;
  cmd_t cmd;
  stat_t stat;
  result_t res;
  logic busy, done, in_fire, out_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) class_count_r <= CountW'(1);
    else if (cfg_we) class_count_r <= cfg_wdata;
  end

  assign in_ch.ready  = !busy;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = done;
  assign out_ch.data  = res;
  assign out_fire     = out_ch.valid && out_ch.ready;

  jic_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_fire, .stat, .cmd, .busy, .done
  );

  jic_datapath #(.MAX_CLASSES(MAX_CLASSES), .MAX_LIST_SLOTS(MAX_LIST_SLOTS)) u_dp (
    .clk, .rst_n, .item(in_ch.data), .class_count(class_count_r), .cmd, .stat, .res
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_fire) else $error("beat accepted while busy");
  a_hit_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.data.is_instance && out_ch.data.error_code != ERR_OK))
    else $error("hit with error");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");

endmodule
